// ===== rtl/fmu_pkg.sv =====
// Shared constants, tables and helper functions of the fuzzy membership update block.
`timescale 1ns / 1ps

package fmu_pkg;

  // Register indexes of the configuration port.
  localparam logic REG_EXPONENT = 1'b0;
  localparam logic REG_CLUSTERS = 1'b1;

  // Register reset values.
  localparam logic [15:0] EXPONENT_RESET = 16'd4096;
  localparam logic [3:0]  CLUSTERS_RESET = 4'd8;

  // Data widths.
  localparam int LG_W       = 22;  // log2 result: 6-bit integer, 16-bit fraction
  localparam int FRAC_STEPS = 16;
  localparam int SUM_W      = 64;
  localparam int QUOT_W     = 17;
  localparam int NUM_W      = 65;
  localparam int DEN_W      = SUM_W + QUOT_W - 1;

  localparam logic [QUOT_W-1:0] MEMB_ONE = 17'd65536;

  typedef logic [31:0] exp_tab_t [FRAC_STEPS];

  // Integer square root, used only to build the constant table below.
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = '0;
    b = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > x) begin
        b = b >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Q2.30 factors 2^(2^-i) for fraction bits i = 1..16.
  function automatic exp_tab_t exp_table();
    exp_tab_t    t;
    logic [63:0] c;
    c = isqrt64(64'h1 << 61);
    for (int i = 0; i < FRAC_STEPS; i++) begin
      t[i] = c[31:0];
      c    = isqrt64(c << 30);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_C = exp_table();

  // Rounded share 1/z in Q1.16 for z zero clusters.
  function automatic logic [QUOT_W-1:0] zero_share(input logic [3:0] z);
    logic [QUOT_W-1:0] v;
    case (z)
      4'd1:    v = 17'd65536;
      4'd2:    v = 17'd32768;
      4'd3:    v = 17'd21845;
      4'd4:    v = 17'd16384;
      4'd5:    v = 17'd13107;
      4'd6:    v = 17'd10923;
      4'd7:    v = 17'd9362;
      4'd8:    v = 17'd8192;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/fmu_div.sv =====
// Restoring divider that turns the term sum into a rounded membership quotient.
`timescale 1ns / 1ps

module fmu_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fmu_pkg::SUM_W-1:0] sum_i,
  output logic                      done_o,
  output logic [fmu_pkg::QUOT_W-1:0] quot_o
);
  import fmu_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [4:0]          cnt_q;
  logic [NUM_W-1:0]    num_q;
  logic [DEN_W-1:0]    den_q;
  logic [QUOT_W-1:0]   quot_q;
  logic                ge;

  assign ge     = {{(DEN_W-NUM_W){1'b0}}, num_q} >= den_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  // Control: one quotient bit per cycle, most significant first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(QUOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: numerator is 2^32 + s/2, divisor starts at s aligned to the top quotient bit.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= (NUM_W'(1) << 32) + NUM_W'(sum_i >> 1);
      den_q  <= {sum_i, {(QUOT_W-1){1'b0}}};
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        num_q <= num_q - den_q[NUM_W-1:0];
      end
      quot_q <= {quot_q[QUOT_W-2:0], ge};
      den_q  <= den_q >> 1;
    end
  end

endmodule

// ===== rtl/fuzzy_membership_update.sv =====
// Top level of the fuzzy membership update block: accumulation, log/exp sequencer, output.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   mode, cluster_index, matrix_index, value,
//                                                 object_last
//   out      output     out_valid_o / out_ready_i result_cluster, membership, result_last
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// A weight transaction is a single memory write; a dissimilarity transaction does a memory read,
// multiply and saturating add, the multiply through the one shared 32x32 multiplier.
// Finalization for n clusters: a zero scan, then per cluster a one-bit normalization and
// squaring, n*n pairs (exponent product, 16 exp2 steps) and the bit-serial divider per
// cluster; if any cluster is zero, only the zero shares are output after the scan.
// Reset clears the control and the accumulator valid bits and loads the configuration reset values at once.
// A stalled output only holds the sequencer at the next result; input is not taken meanwhile.
`timescale 1ns / 1ps

module fuzzy_membership_update #(
  parameter int MAX_CLUSTERS = 8,
  parameter int MAX_MATRICES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [2:0]  cluster_index_i,
  input  logic [1:0]  matrix_index_i,
  input  logic [31:0] value_i,
  input  logic        object_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_cluster_o,
  output logic [16:0] membership_o,
  output logic        result_last_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);
  import fmu_pkg::*;

  localparam int NACC = (MAX_CLUSTERS < 8) ? MAX_CLUSTERS : 8;
  localparam int AW   = $clog2(NACC);
  localparam int WD   = MAX_CLUSTERS * MAX_MATRICES;
  localparam int WAW  = (WD > 1) ? $clog2(WD) : 1;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_ACC_MUL  = 5'd1;
  localparam logic [4:0] S_ACC_ADD  = 5'd2;
  localparam logic [4:0] S_Z_RD     = 5'd3;
  localparam logic [4:0] S_Z_CHK    = 5'd4;
  localparam logic [4:0] S_SH_RD    = 5'd5;
  localparam logic [4:0] S_SH_OUT   = 5'd6;
  localparam logic [4:0] S_LG_RD    = 5'd7;
  localparam logic [4:0] S_LG_LOAD  = 5'd8;
  localparam logic [4:0] S_LG_NORM  = 5'd9;
  localparam logic [4:0] S_LG_SQ    = 5'd10;
  localparam logic [4:0] S_LG_BIT   = 5'd11;
  localparam logic [4:0] S_PK_RD    = 5'd12;
  localparam logic [4:0] S_PK_LOAD  = 5'd13;
  localparam logic [4:0] S_PH_RD    = 5'd14;
  localparam logic [4:0] S_PH_MUL   = 5'd15;
  localparam logic [4:0] S_PH_SHIFT = 5'd16;
  localparam logic [4:0] S_EX_MUL   = 5'd17;
  localparam logic [4:0] S_EX_UPD   = 5'd18;
  localparam logic [4:0] S_TERM     = 5'd19;
  localparam logic [4:0] S_DIV      = 5'd20;
  localparam logic [4:0] S_OUT      = 5'd21;

  // Configuration registers.
  logic [15:0] exponent_q;
  logic [3:0]  clusters_q;

  // Control state.
  logic [4:0]       state_q, state_d;
  logic [AW-1:0]    k_q, k_d;
  logic [AW-1:0]    h_q, h_d;
  logic [4:0]       j_q, j_d;
  logic [3:0]       z_q, z_d;
  logic [NACC-1:0]  acc_vld_q, acc_vld_d;
  logic             out_valid_q, out_valid_d;

  // Payload registers.
  logic [2:0]        ci_q;
  logic              ok_q;
  logic              last_q;
  logic [31:0]       val_q;
  logic [63:0]       mul_q;
  logic [63:0]       x_q;
  logic [5:0]        p_q;
  logic [31:0]       m_q;
  logic [15:0]       frac_q;
  logic [LG_W-1:0]   lgk_q;
  logic              neg_q;
  logic [10:0]       ip_q;
  logic [15:0]       f_q;
  logic [31:0]       r_q;
  logic [SUM_W-1:0]  s_q;
  logic [2:0]        out_cluster_q;
  logic [QUOT_W-1:0] out_memb_q;
  logic              out_last_q;

  // Memories.
  logic [31:0]     w_mem [WD];
  logic [31:0]     w_rd_q;
  logic [63:0]     acc_mem [NACC];
  logic [63:0]     acc_rd_q;
  logic            acc_rdv_q;
  logic [LG_W-1:0] lg_mem [NACC];
  logic [LG_W-1:0] lg_rd_q;

  logic            in_fire;
  logic            in_ok;
  logic [31:0]     w_addr_full;
  logic [WAW-1:0]  w_addr;
  logic [AW-1:0]   acc_ra;
  logic [AW-1:0]   lg_ra;
  logic [63:0]     acc_val;
  logic [3:0]      n_use;
  logic            k_is_last;
  logic            h_is_last;
  logic            slot_free;
  logic [31:0]     mul_a, mul_b;
  logic [64:0]     acc_sum;
  logic            acc_we;
  logic [32:0]     sq;
  logic            frac_bit;
  logic [15:0]     frac_next;
  logic            lg_we;
  logic [22:0]     diff;
  logic [21:0]     diff_mag;
  logic [38:0]     prod_s;
  logic [11:0]     sh;
  logic [63:0]     term;
  logic [64:0]     s_sum;
  logic [SUM_W-1:0] s_next;
  logic            div_start;
  logic            div_done;
  logic [QUOT_W-1:0] div_quot;
  logic [3:0]      z_inc;
  logic            emit;
  logic [QUOT_W-1:0] emit_memb;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign in_ok       = (32'(cluster_index_i) < 32'(MAX_CLUSTERS)) &&
                       (32'(matrix_index_i) < 32'(MAX_MATRICES));
  assign w_addr_full = 32'(cluster_index_i) * 32'(MAX_MATRICES) + 32'(matrix_index_i);
  assign w_addr      = w_addr_full[WAW-1:0];
  // The accumulator of the pending term stays addressed while the product is formed.
  assign acc_ra      = (state_q == S_IDLE)    ? cluster_index_i[AW-1:0] :
                       (state_q == S_ACC_MUL) ? ci_q[AW-1:0] : k_q;
  assign lg_ra       = (state_q == S_PH_RD) ? h_q : k_q;
  assign acc_val     = acc_rdv_q ? acc_rd_q : 64'd0;
  assign slot_free   = !out_valid_q || out_ready_i;

  // Clusters in use: zero acts as one, large values are capped.
  always_comb begin
    if (clusters_q == 4'd0) begin
      n_use = 4'd1;
    end else if (32'(clusters_q) > NACC) begin
      n_use = 4'(NACC);
    end else begin
      n_use = clusters_q;
    end
  end

  assign k_is_last = (4'(k_q) == n_use - 4'd1);
  assign h_is_last = (4'(h_q) == n_use - 4'd1);

  // Operand selection for the shared multiplier.
  assign diff     = {1'b0, lgk_q} - {1'b0, lg_rd_q};
  assign diff_mag = diff[22] ? 22'(-diff) : diff[21:0];

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_q)
      S_ACC_MUL: begin
        mul_a = w_rd_q;
        mul_b = val_q;
      end
      S_LG_SQ: begin
        mul_a = m_q;
        mul_b = m_q;
      end
      S_PH_MUL: begin
        mul_a = {10'd0, diff_mag};
        mul_b = {16'd0, exponent_q};
      end
      S_EX_MUL: begin
        mul_a = r_q;
        mul_b = EXP_C[j_q[3:0]];
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // Saturating accumulation.
  assign acc_sum = {1'b0, acc_val} + {1'b0, mul_q};
  assign acc_we  = (state_q == S_ACC_ADD) && ok_q;

  // One log2 fraction bit from the squared mantissa.
  assign sq        = mul_q[63:31];
  assign frac_bit  = sq[32];
  assign frac_next = {frac_q[14:0], frac_bit};
  assign lg_we     = (state_q == S_LG_BIT) && (j_q == 5'(FRAC_STEPS - 1));

  // Signed exponent product; the upper slice is the floor of the shifted value.
  assign prod_s = neg_q ? 39'(-mul_q[38:0]) : mul_q[38:0];

  // Term alignment from the integer part of the exponent.
  assign sh = {ip_q[10], ip_q} - 12'sd14;

  always_comb begin
    if ($signed(sh) >= 12'sd33) begin
      term = 64'h1 << 63;
    end else if ($signed(sh) >= 12'sd0) begin
      term = {32'd0, r_q} << sh[5:0];
    end else if ($signed(sh) <= -12'sd31) begin
      term = 64'd0;
    end else begin
      term = {32'd0, r_q} >> 5'(-sh);
    end
  end

  assign s_sum     = {1'b0, s_q} + {1'b0, term};
  assign s_next    = s_sum[64] ? {SUM_W{1'b1}} : s_sum[SUM_W-1:0];
  assign div_start = (state_q == S_TERM) && h_is_last;
  assign z_inc     = (acc_val == 64'd0) ? z_q + 4'd1 : z_q;

  // Result for the current cluster.
  always_comb begin
    emit      = 1'b0;
    emit_memb = '0;
    if (state_q == S_SH_OUT && slot_free) begin
      emit      = 1'b1;
      emit_memb = (acc_val == 64'd0) ? zero_share(z_q) : '0;
    end else if (state_q == S_OUT && slot_free) begin
      emit      = 1'b1;
      emit_memb = (div_quot > MEMB_ONE) ? MEMB_ONE : div_quot;
    end
  end

  fmu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (s_next),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    h_d         = h_q;
    j_d         = j_q;
    z_d         = z_q;
    acc_vld_d   = acc_vld_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (acc_we) begin
      acc_vld_d[ci_q[AW-1:0]] = 1'b1;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && mode_i) begin
          state_d = S_ACC_MUL;
        end
      end
      S_ACC_MUL: state_d = S_ACC_ADD;
      S_ACC_ADD: begin
        if (last_q) begin
          k_d     = '0;
          z_d     = '0;
          state_d = S_Z_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_Z_RD: state_d = S_Z_CHK;
      S_Z_CHK: begin
        z_d = z_inc;
        if (k_is_last) begin
          k_d     = '0;
          state_d = (z_inc != 4'd0) ? S_SH_RD : S_LG_RD;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_Z_RD;
        end
      end
      S_SH_RD: state_d = S_SH_OUT;
      S_SH_OUT: begin
        if (slot_free) begin
          if (k_is_last) begin
            acc_vld_d = '0;
            state_d   = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_SH_RD;
          end
        end
      end
      S_LG_RD:   state_d = S_LG_LOAD;
      S_LG_LOAD: state_d = S_LG_NORM;
      S_LG_NORM: begin
        if (x_q[63]) begin
          j_d     = '0;
          state_d = S_LG_SQ;
        end
      end
      S_LG_SQ: state_d = S_LG_BIT;
      S_LG_BIT: begin
        if (j_q == 5'(FRAC_STEPS - 1)) begin
          if (k_is_last) begin
            k_d     = '0;
            state_d = S_PK_RD;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_LG_RD;
          end
        end else begin
          j_d     = j_q + 5'd1;
          state_d = S_LG_SQ;
        end
      end
      S_PK_RD: state_d = S_PK_LOAD;
      S_PK_LOAD: begin
        h_d     = '0;
        state_d = S_PH_RD;
      end
      S_PH_RD:    state_d = S_PH_MUL;
      S_PH_MUL:   state_d = S_PH_SHIFT;
      S_PH_SHIFT: begin
        j_d     = '0;
        state_d = S_EX_MUL;
      end
      S_EX_MUL: state_d = S_EX_UPD;
      S_EX_UPD: begin
        if (j_q == 5'(FRAC_STEPS - 1)) begin
          state_d = S_TERM;
        end else begin
          j_d     = j_q + 5'd1;
          state_d = S_EX_MUL;
        end
      end
      S_TERM: begin
        if (h_is_last) begin
          state_d = S_DIV;
        end else begin
          h_d     = h_q + 1'b1;
          state_d = S_PH_RD;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          if (k_is_last) begin
            acc_vld_d = '0;
            state_d   = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_PK_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      h_q         <= '0;
      j_q         <= '0;
      z_q         <= '0;
      acc_vld_q   <= '0;
      out_valid_q <= 1'b0;
      exponent_q  <= EXPONENT_RESET;
      clusters_q  <= CLUSTERS_RESET;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      h_q         <= h_d;
      j_q         <= j_d;
      z_q         <= z_d;
      acc_vld_q   <= acc_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_EXPONENT: exponent_q <= cfg_wdata_i;
          REG_CLUSTERS: clusters_q <= cfg_wdata_i[3:0];
          default:      exponent_q <= exponent_q;
        endcase
      end
    end
  end

  // Memories with registered reads.
  always_ff @(posedge clk_i) begin
    if (in_fire && !mode_i && in_ok) begin
      w_mem[w_addr] <= value_i;
    end
    w_rd_q <= w_mem[w_addr];
    if (acc_we) begin
      acc_mem[ci_q[AW-1:0]] <= acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];
    end
    acc_rd_q  <= acc_mem[acc_ra];
    acc_rdv_q <= acc_vld_q[acc_ra];
    if (lg_we) begin
      lg_mem[k_q] <= {p_q, frac_next};
    end
    lg_rd_q <= lg_mem[lg_ra];
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    if (in_fire) begin
      ci_q   <= cluster_index_i;
      ok_q   <= in_ok;
      last_q <= object_last_i;
      val_q  <= value_i;
    end
    case (state_q)
      S_LG_LOAD: begin
        x_q <= acc_val;
        p_q <= 6'd63;
      end
      S_LG_NORM: begin
        if (x_q[63]) begin
          m_q    <= x_q[63:32];
          frac_q <= '0;
        end else begin
          x_q <= x_q << 1;
          p_q <= p_q - 6'd1;
        end
      end
      S_LG_BIT: begin
        m_q    <= frac_bit ? sq[32:1] : sq[31:0];
        frac_q <= frac_next;
      end
      S_PK_LOAD: begin
        lgk_q <= lg_rd_q;
        s_q   <= '0;
      end
      S_PH_MUL: neg_q <= diff[22];
      S_PH_SHIFT: begin
        ip_q <= prod_s[38:28];
        f_q  <= prod_s[27:12];
        r_q  <= 32'h4000_0000;
      end
      S_EX_UPD: begin
        if (f_q[4'(FRAC_STEPS - 1) - j_q[3:0]]) begin
          r_q <= mul_q[61:30];
        end
      end
      S_TERM: s_q <= s_next;
      default: begin
        s_q <= s_q;
      end
    endcase
    if (emit) begin
      out_cluster_q <= 3'(k_q);
      out_memb_q    <= emit_memb;
      out_last_q    <= k_is_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_cluster_o = out_cluster_q;
  assign membership_o     = out_memb_q;
  assign result_last_o    = out_last_q;

endmodule
